/* rtl/jmcs_pkg.sv */
// ----------------------------------------------------------------------------
// jmcs_pkg
// shared types and constants of the jack matrix change scanner
// ----------------------------------------------------------------------------
package jmcs_pkg;

  // field widths of the scan transactions
  localparam int unsigned LINE_W    = 4;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned MAP_LINES = 16;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // event codes
  localparam logic [1:0] CODE_OPEN      = 2'd1;
  localparam logic [1:0] CODE_CONNECTED = 2'd2;

  // one classified scan, handed from front to back
  typedef struct packed {
    logic [LINE_W-1:0]  drv;      // driven line
    logic [LEVEL_W-1:0] changes;  // lines whose connection flipped
    logic [LEVEL_W-1:0] conn;     // new connection state of every line
  } scan_item_t;

endpackage

/* rtl/jmcs_front.sv */
// ----------------------------------------------------------------------------
// jmcs_front
// accepts scan transactions, compares them with the connection map, updates
// the map and queues the set of changed lines
// ----------------------------------------------------------------------------
module jmcs_front #(
  parameter int unsigned NUM_LINES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [jmcs_pkg::LINE_W-1:0] in_driven_line,
  input  logic [jmcs_pkg::LEVEL_W-1:0] in_pin_levels,
  output logic                        q_push,
  output jmcs_pkg::scan_item_t        q_item,
  input  logic                        q_full
);
  import jmcs_pkg::*;

  // the fields carry at most sixteen lines
  localparam int unsigned ActiveLines = (NUM_LINES > MAP_LINES) ? MAP_LINES : NUM_LINES;
  localparam int unsigned IdxW        = $clog2(ActiveLines);
  localparam logic [LEVEL_W-1:0] LineMask =
    LEVEL_W'((17'd1 << ActiveLines) - 17'd1);

  logic [LEVEL_W-1:0] map_r [ActiveLines];
  logic [IdxW-1:0]    row_idx;
  logic               in_range;
  logic               take;
  logic [LEVEL_W-1:0] row;
  logic [LEVEL_W-1:0] conn;
  logic [LEVEL_W-1:0] own_bit;
  logic [LEVEL_W-1:0] diff;
  logic [LEVEL_W-1:0] row_nxt;

  // classify the incoming scan
  always_comb begin
    in_range = ({1'b0, in_driven_line} < (LINE_W + 1)'(ActiveLines));
    row_idx  = in_driven_line[IdxW-1:0];
    row      = map_r[row_idx];
    conn     = ~in_pin_levels;
    own_bit  = LEVEL_W'(1) << in_driven_line;
    diff     = (row ^ conn) & LineMask & ~own_bit;
    row_nxt  = row ^ diff;
  end

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall && in_range;
  assign q_push   = take && (diff != '0);

  assign q_item.drv     = in_driven_line;
  assign q_item.changes = diff;
  assign q_item.conn    = conn;

  // connection map, all open after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ActiveLines; i++) begin
        map_r[i] <= '0;
      end
    end else if (take) begin
      map_r[row_idx] <= row_nxt;
    end
  end

`ifndef SYNTH
  // the driven line never reports a change against itself
  a_no_self_change: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ((q_item.changes & own_bit) == '0))
    else $error("driven line flagged as changed");

  // only lines inside the active range are reported
  a_changes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ((q_item.changes & ~LineMask) == '0))
    else $error("change outside active lines");

  // an out of range line never leads to a queued scan
  a_range_drop: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_range)
    else $error("out of range scan queued");
`endif

endmodule

/* rtl/jmcs_queue.sv */
// ----------------------------------------------------------------------------
// jmcs_queue
// short fifo of classified scans between front and back
// ----------------------------------------------------------------------------
module jmcs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jmcs_pkg::scan_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 not_empty,
  output jmcs_pkg::scan_item_t head_item
);
  import jmcs_pkg::*;

  scan_item_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue overfilled");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
`endif

endmodule

/* rtl/jmcs_back.sv */
// ----------------------------------------------------------------------------
// jmcs_back
// walks the changed lines of one scan in ascending order and emits one
// event transaction per line through an output register
// ----------------------------------------------------------------------------
module jmcs_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_not_empty,
  input  jmcs_pkg::scan_item_t         q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [jmcs_pkg::LINE_W-1:0]  out_source_line,
  output logic [jmcs_pkg::LINE_W-1:0]  out_sensed_line,
  output logic [1:0]                   out_event_code,
  output logic                         out_last_event
);
  import jmcs_pkg::*;

  // lowest set bit of a change mask
  function automatic logic [LINE_W-1:0] lowest_idx(input logic [LEVEL_W-1:0] v);
    logic [LINE_W-1:0] idx;
    idx = '0;
    for (int i = LEVEL_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = LINE_W'(i);
      end
    end
    return idx;
  endfunction

  logic               busy_r;
  logic [LINE_W-1:0]  drv_r;
  logic [LEVEL_W-1:0] mask_r;
  logic [LEVEL_W-1:0] conn_r;
  logic               out_valid_r;
  logic [LINE_W-1:0]  src_r;
  logic [LINE_W-1:0]  sensed_r;
  logic [1:0]         code_r;
  logic               last_r;

  logic [LINE_W-1:0]  pick;
  logic [LEVEL_W-1:0] pick_bit;
  logic [LEVEL_W-1:0] rest;
  logic               emit;
  logic               fin;
  logic               load;

  // pick the next changed line
  always_comb begin
    pick     = lowest_idx(mask_r);
    pick_bit = LEVEL_W'(1) << pick;
    rest     = mask_r & ~pick_bit;
    emit     = busy_r && (!out_valid_r || !out_stall);
    fin      = emit && (rest == '0);
    load     = q_not_empty && (!busy_r || fin);
  end

  assign q_pop = load;

  // scan walker and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        drv_r  <= q_head.drv;
        mask_r <= q_head.changes;
        conn_r <= q_head.conn;
      end else if (fin) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        mask_r <= rest;
      end

      if (emit) begin
        out_valid_r <= 1'b1;
        src_r       <= drv_r;
        sensed_r    <= pick;
        code_r      <= ((conn_r & pick_bit) != '0) ? CODE_CONNECTED : CODE_OPEN;
        last_r      <= (rest == '0);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_source_line = src_r;
  assign out_sensed_line = sensed_r;
  assign out_event_code  = code_r;
  assign out_last_event  = last_r;

`ifndef SYNTH
  // an active walk always has a line left to report
  a_busy_mask: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (mask_r != '0))
    else $error("walker busy with empty mask");

  // a stalled event stays on the port
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled event dropped");

  // every event finishing a scan is marked last
  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> (out_valid_r && last_r))
    else $error("last marker missing");
`endif

endmodule

/* rtl/jack_matrix_change_scanner.sv */
// ----------------------------------------------------------------------------
// jack_matrix_change_scanner
// patch-jack matrix change detector with serialized change events
// ----------------------------------------------------------------------------
// Usage: each input transaction gives the line driven low and the sampled
// levels of all lines. A low level means the line is patched to the driven
// line. Every other active line whose connection differs from the stored map
// flips its map bit and yields one output transaction (driven line, sensed
// line, code open or connected), in ascending line order, the final one of a
// scan marked with out_last_event. Scans with no change, or with a driven
// line outside the active range, yield nothing.
// Throughput: the front takes one scan per cycle while the two-entry queue
// has room; the back emits one event per cycle while out_stall is low, so a
// scan with k changes yields k events (at most 15 for sixteen lines).
// Path: an accepted scan passes the queue, the walker registers and the
// output register before its first event reaches the port.
// Reset: synchronous, clears the map to all open and empties the queue.
// When out_stall is high the current event holds, the walker pauses and the
// queue fills; in_stall rises once the queue is full.
// ----------------------------------------------------------------------------
module jack_matrix_change_scanner #(
  parameter int unsigned NUM_LINES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [jmcs_pkg::LINE_W-1:0]   in_driven_line,
  input  logic [jmcs_pkg::LEVEL_W-1:0]  in_pin_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jmcs_pkg::LINE_W-1:0]   out_source_line,
  output logic [jmcs_pkg::LINE_W-1:0]   out_sensed_line,
  output logic [1:0]                    out_event_code,
  output logic                          out_last_event
);
  import jmcs_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_not_empty;
  scan_item_t q_in;
  scan_item_t q_head;

  // front: compare with map and classify
  jmcs_front #(
    .NUM_LINES(NUM_LINES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_driven_line (in_driven_line),
    .in_pin_levels  (in_pin_levels),
    .q_push         (q_push),
    .q_item         (q_in),
    .q_full         (q_full)
  );

  // queue between front and back
  jmcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (q_head)
  );

  // back: serialize change events
  jmcs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_line (out_source_line),
    .out_sensed_line (out_sensed_line),
    .out_event_code  (out_event_code),
    .out_last_event  (out_last_event)
  );

endmodule
